>>> design/ipca_pkg.sv
// Shared types and constants for the issue port contention arbiter.
`default_nettype none
package ipca_pkg;

   localparam int NUM_PORTS  = 5;
   localparam int TIME_W     = 48;
   localparam int CLASS_W    = 3;
   localparam int ALU_W      = 2;
   localparam int LAT_W      = 8;
   localparam int CNT_W      = 2;
   localparam int CAUSE_W    = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // port flag slots
   localparam int PORT_P0  = 0;
   localparam int PORT_P1  = 1;
   localparam int PORT_P5  = 2;
   localparam int PORT_P2  = 3;
   localparam int PORT_P34 = 4;

   // beat kinds
   localparam logic KIND_CYCLE_START = 1'b0;
   localparam logic KIND_ISSUE       = 1'b1;

   // port classes
   localparam logic [CLASS_W-1:0] CLASS_P0    = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_P1    = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_P5    = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_P015  = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_P05   = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_LOAD  = 3'd5;
   localparam logic [CLASS_W-1:0] CLASS_STORE = 3'd6;

   // reject causes
   localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_PORT      = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_UNIT_BUSY = 2'd2;

   // register indexes (byte address bit 2)
   localparam logic REG_SHARED_LIMIT = 1'b0;
   localparam logic REG_PAIR_LIMIT   = 1'b1;

   localparam logic [CNT_W-1:0] SHARED_LIMIT_RESET = 2'd3;
   localparam logic [CNT_W-1:0] PAIR_LIMIT_RESET   = 2'd2;

   typedef struct packed {
      logic                 port_ok;
      logic [NUM_PORTS-1:0] port_claim;
      logic                 raise_shared;
      logic                 raise_pair;
   } ipca_check_type;

endpackage
`default_nettype wire

>>> design/ipca_port_check.sv
// Port class decode and port / shared-limit availability check.
`default_nettype none
module ipca_port_check (
   input  wire logic [ipca_pkg::CLASS_W-1:0]   port_class,
   input  wire logic [ipca_pkg::NUM_PORTS-1:0] port_taken,
   input  wire logic [ipca_pkg::CNT_W-1:0]     shared_count,
   input  wire logic [ipca_pkg::CNT_W-1:0]     pair_count,
   input  wire logic [ipca_pkg::CNT_W-1:0]     shared_limit,
   input  wire logic [ipca_pkg::CNT_W-1:0]     pair_limit,
   output ipca_pkg::ipca_check_type            check
);
   import ipca_pkg::*;

   logic known_class;

   always_comb begin
      check.port_claim   = '0;
      check.raise_shared = 1'b0;
      check.raise_pair   = 1'b0;
      known_class        = 1'b1;
      unique case (port_class)
         CLASS_P0: begin
            check.port_claim[PORT_P0] = 1'b1;
            check.raise_shared = 1'b1;
            check.raise_pair   = 1'b1;
         end
         CLASS_P1: begin
            check.port_claim[PORT_P1] = 1'b1;
            check.raise_shared = 1'b1;
         end
         CLASS_P5: begin
            check.port_claim[PORT_P5] = 1'b1;
            check.raise_shared = 1'b1;
            check.raise_pair   = 1'b1;
         end
         CLASS_P015:  check.raise_shared = 1'b1;
         CLASS_P05:   check.raise_pair = 1'b1;
         CLASS_LOAD:  check.port_claim[PORT_P2] = 1'b1;
         CLASS_STORE: check.port_claim[PORT_P34] = 1'b1;
         default:     known_class = 1'b0;
      endcase

      check.port_ok = known_class
         && ((check.port_claim & port_taken) == '0)
         && !(check.raise_shared && (shared_count >= shared_limit))
         && !(check.raise_pair && (pair_count >= pair_limit));
   end

endmodule
`default_nettype wire

>>> design/issue_port_contention_arbiter.sv
// Top level of the issue port contention arbiter: beat registers, state and CSRs.
`default_nettype none
// Issue port arbiter. Each req beat is either a cycle start (tuser = 0), which
// latches the cycle number and frees all ports and shared counters, or an issue
// request (tuser = 1), which is granted when its port class is free, the 0/1/5
// and 0/5 shared limits are not reached and its execution unit is idle. Every
// beat yields exactly one rsp beat, in order. One beat per clock is sustained
// while the receiver keeps rsp_tready high: a beat sits in the input register,
// where the port check, the unit busy compare and the state update happen in
// one pass, then waits in the result register. Unit indexes at or above
// NUM_UNITS count as no unit. The limits are written over the csr_ port at
// byte 0 (shared 0/1/5 limit) and byte 4 (0/5 pair limit).
module issue_port_contention_arbiter #(
   parameter int NUM_UNITS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: cycle_time[47:0], port_class[50:48], alu_index[52:51],
   //            alu_latency[60:53], zero[63:61]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   // req_tuser: kind[0]
   input  wire logic        req_tuser,
   // rsp_tdata: accepted[0], reject_cause[2:1], ports_exhausted[3], zero[7:4]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [ipca_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ipca_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ipca_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic             csr_pready
);
   import ipca_pkg::*;

   localparam int UNIT_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

   // configuration
   logic [CNT_W-1:0] shared_limit_ff, pair_limit_ff;
   logic             csr_write;

   // input register
   logic               in_valid_ff;
   logic               in_kind_ff;
   logic [TIME_W-1:0]  in_time_ff;
   logic [CLASS_W-1:0] in_class_ff;
   logic [ALU_W-1:0]   in_alu_ff;
   logic [LAT_W-1:0]   in_lat_ff;

   // result register
   logic               out_valid_ff;
   logic               out_accepted_ff, out_accepted_in;
   logic [CAUSE_W-1:0] out_cause_ff, out_cause_in;
   logic               out_exhausted_ff, out_exhausted_in;

   // arbiter state
   logic [TIME_W-1:0]    current_time_ff, current_time_in;
   logic [NUM_PORTS-1:0] port_taken_ff, port_taken_in;
   logic [CNT_W-1:0]     shared_count_ff, shared_count_in;
   logic [CNT_W-1:0]     pair_count_ff, pair_count_in;
   logic [TIME_W-1:0]    busy_until_ff [NUM_UNITS];

   logic               advance, take_req;
   ipca_check_type     check;
   logic               unit_used;
   logic [UNIT_W-1:0]  unit_idx;
   logic               unit_busy;
   logic               grant;
   logic [TIME_W-1:0]  busy_new;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_SHARED_LIMIT: csr_prdata[CNT_W-1:0] = shared_limit_ff;
         REG_PAIR_LIMIT:   csr_prdata[CNT_W-1:0] = pair_limit_ff;
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_limit_ff <= SHARED_LIMIT_RESET;
         pair_limit_ff   <= PAIR_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_SHARED_LIMIT: shared_limit_ff <= csr_pwdata[CNT_W-1:0];
            REG_PAIR_LIMIT:   pair_limit_ff <= csr_pwdata[CNT_W-1:0];
            default:          shared_limit_ff <= shared_limit_ff;
         endcase
      end
   end

   // the input beat is processed when the result register has room
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;

   ipca_port_check u_port_check (
      .port_class   (in_class_ff),
      .port_taken   (port_taken_ff),
      .shared_count (shared_count_ff),
      .pair_count   (pair_count_ff),
      .shared_limit (shared_limit_ff),
      .pair_limit   (pair_limit_ff),
      .check        (check)
   );

   assign unit_used = (in_alu_ff != '0) && (32'(in_alu_ff) < NUM_UNITS);
   assign unit_idx  = UNIT_W'(in_alu_ff);
   assign unit_busy = unit_used && (busy_until_ff[unit_idx] > current_time_ff);
   assign busy_new  = current_time_ff + TIME_W'(in_lat_ff);
   assign grant     = (in_kind_ff == KIND_ISSUE) && check.port_ok && !unit_busy;

   always_comb begin
      current_time_in = current_time_ff;
      port_taken_in   = port_taken_ff;
      shared_count_in = shared_count_ff;
      pair_count_in   = pair_count_ff;
      out_accepted_in = 1'b0;
      out_cause_in    = CAUSE_NONE;
      if (in_kind_ff == KIND_CYCLE_START) begin
         current_time_in = in_time_ff;
         port_taken_in   = '0;
         shared_count_in = '0;
         pair_count_in   = '0;
      end else if (!check.port_ok) begin
         out_cause_in = CAUSE_PORT;
      end else if (unit_busy) begin
         out_cause_in = CAUSE_UNIT_BUSY;
      end else begin
         out_accepted_in = 1'b1;
         port_taken_in   = port_taken_ff | check.port_claim;
         if (check.raise_shared) shared_count_in = shared_count_ff + 1'b1;
         if (check.raise_pair) pair_count_in = pair_count_ff + 1'b1;
      end
      out_exhausted_in = port_taken_in[PORT_P2] && port_taken_in[PORT_P34]
                         && (shared_count_in >= shared_limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         current_time_ff <= '0;
         port_taken_ff   <= '0;
         shared_count_ff <= '0;
         pair_count_ff   <= '0;
         for (int i = 0; i < NUM_UNITS; i++) busy_until_ff[i] <= '0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff    <= 1'b1;
            current_time_ff <= current_time_in;
            port_taken_ff   <= port_taken_in;
            shared_count_ff <= shared_count_in;
            pair_count_ff   <= pair_count_in;
            if (grant && unit_used) busy_until_ff[unit_idx] <= busy_new;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_kind_ff  <= req_tuser;
         in_time_ff  <= req_tdata[47:0];
         in_class_ff <= req_tdata[50:48];
         in_alu_ff   <= req_tdata[52:51];
         in_lat_ff   <= req_tdata[60:53];
      end
      if (advance) begin
         out_accepted_ff  <= out_accepted_in;
         out_cause_ff     <= out_cause_in;
         out_exhausted_ff <= out_exhausted_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_exhausted_ff, out_cause_ff, out_accepted_ff};

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the issue port contention arbiter: random stream traffic, CSR phases.
module tb;
   import ipca_pkg::*;

   localparam int NUM_UNITS      = 4;
   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 600;
   localparam int PHASE_ITEMS    = 125;
   localparam logic [CLASS_W-1:0] CLASS_UNUSED = 3'd7;
   localparam logic [ALU_W-1:0]   UNIT_NONE    = 2'd0;
   localparam logic [TIME_W-1:0]  TIME_MAX     = {TIME_W{1'b1}};

   // Predicts the grant beat for every request beat and holds the outstanding ones.
   class grant_scoreboard;
      logic [CNT_W-1:0]     shared_limit;
      logic [CNT_W-1:0]     pair_limit;
      logic [TIME_W-1:0]    now_cycle;
      logic [NUM_PORTS-1:0] port_busy;
      logic [CNT_W-1:0]     shared_used;
      logic [CNT_W-1:0]     pair_used;
      logic [TIME_W-1:0]    unit_free_at [NUM_UNITS];
      logic [7:0]           expected_grants [$];
      int                   errors;

      function new();
         shared_limit = SHARED_LIMIT_RESET;
         pair_limit   = PAIR_LIMIT_RESET;
         now_cycle    = '0;
         port_busy    = '0;
         shared_used  = '0;
         pair_used    = '0;
         for (int i = 0; i < NUM_UNITS; i++) unit_free_at[i] = '0;
         errors = 0;
      endfunction

      function void set_limit(logic idx, logic [CNT_W-1:0] value);
         if (idx == REG_SHARED_LIMIT) shared_limit = value;
         else pair_limit = value;
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction

      function void note_request(logic kind, logic [63:0] word);
         logic [CLASS_W-1:0] pclass;
         logic [ALU_W-1:0]   unit;
         logic [LAT_W-1:0]   lat;
         int                 slot;
         bit                 raise_shared, raise_pair, port_ok;
         logic               granted, exhausted;
         logic [CAUSE_W-1:0] cause;
         pclass = word[50:48];
         unit   = word[52:51];
         lat    = word[60:53];
         slot   = -1;
         raise_shared = 1'b0;
         raise_pair   = 1'b0;
         granted = 1'b0;
         cause   = CAUSE_NONE;
         if (kind == KIND_CYCLE_START) begin
            now_cycle   = word[TIME_W-1:0];
            port_busy   = '0;
            shared_used = '0;
            pair_used   = '0;
         end else begin
            case (pclass)
               CLASS_P0: begin
                  slot = PORT_P0; raise_shared = 1'b1; raise_pair = 1'b1;
               end
               CLASS_P1: begin
                  slot = PORT_P1; raise_shared = 1'b1;
               end
               CLASS_P5: begin
                  slot = PORT_P5; raise_shared = 1'b1; raise_pair = 1'b1;
               end
               CLASS_P015:  raise_shared = 1'b1;
               CLASS_P05:   raise_pair = 1'b1;
               CLASS_LOAD:  slot = PORT_P2;
               CLASS_STORE: slot = PORT_P34;
               default: ;
            endcase
            port_ok = (pclass != CLASS_UNUSED);
            if (slot >= 0 && port_busy[slot]) port_ok = 1'b0;
            if (raise_shared && shared_used >= shared_limit) port_ok = 1'b0;
            if (raise_pair && pair_used >= pair_limit) port_ok = 1'b0;
            if (int'(unit) >= NUM_UNITS) unit = UNIT_NONE;
            if (!port_ok) begin
               cause = CAUSE_PORT;
            end else if (unit != UNIT_NONE && unit_free_at[unit] > now_cycle) begin
               cause = CAUSE_UNIT_BUSY;
            end else begin
               if (slot >= 0) port_busy[slot] = 1'b1;
               if (raise_shared) shared_used = shared_used + 1'b1;
               if (raise_pair) pair_used = pair_used + 1'b1;
               // busy time wraps at the time width
               if (unit != UNIT_NONE)
                  unit_free_at[unit] = now_cycle + {{(TIME_W-LAT_W){1'b0}}, lat};
               granted = 1'b1;
            end
         end
         exhausted = port_busy[PORT_P2] && port_busy[PORT_P34] && (shared_used >= shared_limit);
         expected_grants.push_back({4'b0000, exhausted, cause, granted});
      endfunction

      function void check_result(logic [7:0] word);
         logic [7:0] want;
         if (expected_grants.size() == 0) begin
            $error("rsp beat 0x%02h with no request outstanding", word);
            errors++;
            return;
         end
         want = expected_grants.pop_front();
         if (word[0] !== want[0]) begin
            $error("accepted: expected %0d, got %0d", want[0], word[0]);
            errors++;
         end
         if (word[2:1] !== want[2:1]) begin
            $error("reject_cause: expected %0d, got %0d", want[2:1], word[2:1]);
            errors++;
         end
         if (word[3] !== want[3]) begin
            $error("ports_exhausted: expected %0d, got %0d", want[3], word[3]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [63:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   grant_scoreboard grants = new();
   int              rsp_beats = 0;
   int              idle_cycles = 0;
   int              burst_left = 0;
   logic [TIME_W-1:0] cycle_now = '0;

   issue_port_contention_arbiter #(.NUM_UNITS(NUM_UNITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) grants.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            grants.check_result(rsp_tdata);
            rsp_beats++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[issue_port_contention_arbiter] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: changing stall patterns, plus one long hold-off that backs up the block.
   initial begin
      int mode, span, hold_left;
      bit hold_done;
      mode = 0;
      span = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_beats >= 250) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(8, 60);
            end
            span--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 2) != 0);
               2: rsp_tready <= (span % 4 == 0);
               default: rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand48();
      logic [31:0] hi, lo;
      hi = $urandom;
      lo = $urandom;
      return {hi[15:0], lo};
   endfunction

   function automatic logic [63:0] issue_word(logic [CLASS_W-1:0] pclass, logic [ALU_W-1:0] unit,
                                              logic [LAT_W-1:0] lat, logic [TIME_W-1:0] filler);
      return {3'b000, lat, unit, pclass, filler};
   endfunction

   // fields other than the time are ignored on a cycle start; fill them with junk
   function automatic logic [63:0] start_word(logic [TIME_W-1:0] t);
      logic [31:0] junk;
      junk = $urandom;
      return {3'b000, junk[12:0], t};
   endfunction

   function automatic logic [CLASS_W-1:0] rand_class();
      if ($urandom_range(0, 11) == 0) return CLASS_UNUSED;
      return CLASS_W'($urandom_range(0, 6));
   endfunction

   function automatic logic [LAT_W-1:0] rand_latency();
      if ($urandom_range(0, 7) == 0) return LAT_W'($urandom_range(0, 255));
      return LAT_W'($urandom_range(0, 6));
   endfunction

   task automatic send_beat(input logic kind, input logic [63:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic issue(input logic [CLASS_W-1:0] pclass, input logic [ALU_W-1:0] unit,
                        input logic [LAT_W-1:0] lat);
      send_beat(KIND_ISSUE, issue_word(pclass, unit, lat, rand48()));
   endtask

   // stop offering and wait until every outstanding grant has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (grants.pending() != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic idx, input logic [CNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[CNT_W-1:0] = value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      grants.set_limit(idx, value);
   endtask

   task automatic directed_beats();
      send_beat(KIND_CYCLE_START, start_word('0));
      issue(CLASS_P0, 2'd1, 8'd5);
      issue(CLASS_P0, UNIT_NONE, 8'd0);        // port already taken
      issue(CLASS_P1, 2'd1, 8'd1);             // unit still busy
      issue(CLASS_P1, UNIT_NONE, 8'd0);
      issue(CLASS_P5, 2'd2, 8'd0);             // reaches both limits
      issue(CLASS_P015, UNIT_NONE, 8'd3);      // shared limit reached
      issue(CLASS_P05, 2'd1, 8'd3);            // port and unit both blocked
      issue(CLASS_LOAD, 2'd3, 8'd255);
      issue(CLASS_STORE, UNIT_NONE, 8'd0);     // all ports used
      issue(CLASS_UNUSED, 2'd3, 8'd255);
      send_beat(KIND_CYCLE_START, start_word(48'd5));
      issue(CLASS_P015, 2'd1, 8'd255);         // busy until equals now: free
      issue(CLASS_P05, 2'd2, 8'd7);
      issue(CLASS_P015, 2'd3, 8'd0);
      send_beat(KIND_CYCLE_START, start_word(TIME_MAX));
      issue(CLASS_LOAD, 2'd2, 8'd255);         // busy time wraps past zero
      issue(CLASS_STORE, 2'd2, 8'd1);
      send_beat(KIND_CYCLE_START, start_word('0));
      issue(CLASS_P1, 2'd1, 8'd0);
      issue(CLASS_P5, 2'd2, 8'd255);
      issue(CLASS_P0, 2'd3, 8'd0);
   endtask

   // one cycle start and its requests, or now and then some stray beats
   task automatic random_group(inout int sent);
      int n;
      if ($urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, 4);
         repeat (n) send_beat(KIND_ISSUE, issue_word(rand_class(),
                                                     ALU_W'($urandom_range(0, 3)),
                                                     LAT_W'($urandom_range(0, 255)),
                                                     rand48()));
         sent += n;
         if ($urandom_range(0, 1) == 0) begin
            send_beat(KIND_CYCLE_START, start_word(rand48()));
            sent++;
         end
      end else begin
         case ($urandom_range(0, 39))
            0: cycle_now = rand48();
            1: cycle_now = TIME_MAX - $urandom_range(0, 3);
            default: cycle_now = cycle_now + $urandom_range(0, 3);
         endcase
         send_beat(KIND_CYCLE_START, start_word(cycle_now));
         n = $urandom_range(1, 9);
         repeat (n) issue(rand_class(), ALU_W'($urandom_range(0, 3)), rand_latency());
         sent += n + 1;
      end
   endtask

   task automatic run_phase(input bit set_regs, input logic [CNT_W-1:0] shared_lim,
                            input logic [CNT_W-1:0] pair_lim, input bit pause_midway);
      int sent;
      bit paused;
      sent = 0;
      paused = 1'b0;
      if (set_regs) begin
         drain();
         repeat (4) @(negedge clock);
         write_limit(REG_SHARED_LIMIT, shared_lim);
         write_limit(REG_PAIR_LIMIT, pair_lim);
      end
      while (sent < PHASE_ITEMS) begin
         random_group(sent);
         if (pause_midway && !paused && sent >= PHASE_ITEMS / 2) begin
            paused = 1'b1;
            drain();
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_beats();
      run_phase(1'b0, SHARED_LIMIT_RESET, PAIR_LIMIT_RESET, 1'b0);
      run_phase(1'b1, 2'd0, 2'd0, 1'b0);
      run_phase(1'b1, 2'd3, 2'd3, 1'b1);
      run_phase(1'b1, 2'd1, 2'd2, 1'b0);
      run_phase(1'b1, 2'd2, 2'd1, 1'b0);
      run_phase(1'b1, CNT_W'($urandom_range(0, 3)), CNT_W'($urandom_range(0, 3)), 1'b0);

      drain();
      repeat (8) @(negedge clock);
      if (grants.pending() != 0) begin
         $error("%0d grant beats never arrived", grants.pending());
         grants.errors++;
      end
      if (grants.errors == 0) begin
         $display("[issue_port_contention_arbiter] OK");
      end else begin
         $display("[issue_port_contention_arbiter] ERROR");
      end
      $finish;
   end

endmodule

>>> issue_port_contention_arbiter.f
design/ipca_pkg.sv
design/ipca_port_check.sv
design/issue_port_contention_arbiter.sv
test/tb.sv
